// ===== hw/rtl/erv_pkg.sv =====
package erv_pkg;

    localparam int unsigned MAX_LENGTH_BYTES_DEF = 5;
    localparam int unsigned COUNT_WIDTH_DEF      = 32;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
    localparam int unsigned DATA_BITS  = 7;
    localparam int unsigned MORE_BIT   = 7;

    localparam int unsigned RUN_W = 32;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        logic             valid;
        logic [7:0]       pixel_index;
        logic [RUN_W-1:0] run_length;
        logic             bad_run;
    } t_result;

endpackage

// ===== hw/rtl/erv_core.sv =====
module erv_core #(
    parameter int unsigned MAX_LENGTH_BYTES = erv_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int unsigned COUNT_WIDTH      = erv_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_code_byte,
    output erv_pkg::t_result o_result
);
    import erv_pkg::*;

    localparam int unsigned PART_W = DATA_BITS * MAX_LENGTH_BYTES;
    localparam int unsigned EXT_W  = (PART_W > COUNT_WIDTH) ? PART_W : COUNT_WIDTH;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic [2:0]             r_idx, n_idx;
    logic                   r_ovf, n_ovf;

    logic [5:0]             w_shamt;
    logic [EXT_W-1:0]       w_part;
    logic                   w_bad;
    logic                   w_more;

    // shift amount = 7 * index
    assign w_shamt = {r_idx, 3'b000} - {3'b000, r_idx};
    assign w_part  = EXT_W'(i_code_byte[DATA_BITS-1:0]) << w_shamt;
    assign w_bad   = r_ovf || (r_acc == '0);
    assign w_more  = i_code_byte[MORE_BIT];

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_COUNT: begin
                if (!w_more) n_phase = PH_VALUE;
            end
            PH_VALUE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = (i_code_byte == ESCAPE_BYTE) ? PH_COUNT : PH_IDLE;
            end
        endcase
    end

    // count state and result
    always_comb begin
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_ovf    = r_ovf;
        o_result = '0;
        o_result.pixel_index = i_code_byte;
        case (r_phase)
            PH_COUNT: begin
                if (r_idx < 3'(MAX_LENGTH_BYTES)) begin
                    n_acc = r_acc | w_part[COUNT_WIDTH-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_idx != 3'd7) n_idx = r_idx + 3'd1;
            end
            PH_VALUE: begin
                o_result.valid      = 1'b1;
                o_result.bad_run    = w_bad;
                o_result.run_length = w_bad ? '0 : RUN_W'(r_acc);
                n_acc = '0;
                n_idx = '0;
                n_ovf = 1'b0;
            end
            default: begin
                // escape clears the count state; literal leaves it clear
                n_acc = '0;
                n_idx = '0;
                n_ovf = 1'b0;
                if (i_code_byte != ESCAPE_BYTE) begin
                    o_result.valid      = 1'b1;
                    o_result.run_length = RUN_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
        end
    end

    a_count_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COUNT) |-> !o_result.valid)
        else $error("result produced on a count byte");

    a_value_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_VALUE) |=>
            (r_phase == PH_IDLE && r_acc == '0 && r_idx == '0 && !r_ovf))
        else $error("run state not cleared after value byte");

    a_ovf_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_idx >= 3'(MAX_LENGTH_BYTES)))
        else $error("overflow flagged before count byte limit");

endmodule

// ===== hw/rtl/escape_rle_varint_decoder_top.sv =====
// Escape run-length decoder with a 7-bit-per-byte little-endian run count.
// Slave channel (i_s_*): one compressed byte per item in tdata[7:0].
//   Byte 255 opens a run: count bytes follow (bit 7 = another follows),
//   then one value byte. Any other byte outside a run is a literal.
// Master channel (o_m_*): one item per literal or finished run.
//   tdata[7:0] = pixel_index, tdata[39:8] = run_length; tuser = bad_run.
//   A bad run (zero count, or more than MAX_LENGTH_BYTES count bytes) comes
//   out with bad_run 1 and run_length 0.
// The result of a byte is on the master side the cycle after that byte is
//   accepted. Escape and count bytes produce no item.
// Throughput: one byte per cycle unless stalled. The single output register
//   is refilled in the same cycle it is drained, so o_s_tready = !full || i_m_tready.
// Stall: while the output item waits for i_m_tready, o_s_tready drops and
//   the decode state holds; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): phase returns to literal/escape, run
//   state clears and the output register empties.
module escape_rle_varint_decoder_top #(
    parameter int unsigned MAX_LENGTH_BYTES = erv_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int unsigned COUNT_WIDTH      = erv_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] pixel_index, [39:8] run_length
    output logic        o_m_tuser    // [0] bad_run
);
    import erv_pkg::*;

    logic    w_accept;
    t_result w_res;

    logic             r_out_valid;
    logic [7:0]       r_pixel;
    logic [RUN_W-1:0] r_run;
    logic             r_bad;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    erv_core #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_code_byte(i_s_tdata),
        .o_result   (w_res)
    );

    // output register: valid bit under reset, payload loads on accept of a byte with a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= w_accept && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res.valid) begin
            r_pixel <= w_res.pixel_index;
            r_run   <= w_res.run_length;
            r_bad   <= w_res.bad_run;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_run, r_pixel};
    assign o_m_tuser  = r_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[39:8] == '0))
        else $error("bad run with nonzero length");

    a_good_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[39:8] != '0))
        else $error("good run with zero length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_accept)
        else $error("input accepted while output item stalled");

endmodule
